// ----- sv/b2a_pkg.sv -----
package b2a_pkg;

  localparam int unsigned NumDigits     = 10;
  localparam int unsigned DecRadix      = 10;
  localparam int unsigned NumMult       = DecRadix - 1;
  localparam int unsigned ValueW        = 32;
  localparam int unsigned DigitW        = 4;
  localparam int unsigned CharW         = 8;
  localparam int unsigned PosW          = $clog2(NumDigits);
  localparam int unsigned MultW         = 36;
  localparam int unsigned QueueDepthDef = 2;

  localparam logic [PosW-1:0]   LastPos        = PosW'(NumDigits - 1);
  localparam logic [DigitW-1:0] MaxDecDigit    = DigitW'(DecRadix - 1);
  localparam logic [PosW-1:0]   LastHexNibble  = PosW'(ValueW / DigitW - 1);
  localparam logic [CharW-1:0]  AsciiZero      = 8'h30;
  localparam logic [CharW-1:0]  AsciiAlphaOfs  = 8'h37;

  typedef enum logic {
    RADIX_HEX = 1'b0,
    RADIX_DEC = 1'b1
  } b2a_radix_e;

  typedef struct packed {
    logic              op;
    logic [ValueW-1:0] number;
  } b2a_in_t;

  typedef struct packed {
    logic [CharW-1:0] digit_char;
    logic             last;
  } b2a_out_t;

  typedef struct packed {
    b2a_radix_e        radix;
    logic [ValueW-1:0] value;
  } b2a_cmd_t;

  typedef struct packed {
    logic full;
    logic avail;
  } b2a_qstat_t;

  // d * 10^p, elaboration-time only
  function automatic logic [MultW-1:0] dec_mult(input int unsigned p, input int unsigned d);
    logic [MultW-1:0] acc;
    acc = MultW'(d);
    for (int i = 0; i < p; i++) begin
      acc = acc * MultW'(DecRadix);
    end
    return acc;
  endfunction

endpackage

// ----- sv/binary_to_ascii_digits.sv -----
// binary_to_ascii_digits
// converts a 32-bit unsigned value to ten ascii characters, most significant first
// input channel: item_i (op, number) is taken at a rising edge where start_i is high
// and busy_o is low; op = 1 selects decimal, op = 0 upper-case hex
// output channel: result_valid_o strobes one character per cycle on result_o;
// result_o.last marks the tenth character of the run
// path: an accepted command passes the front register, the queue and the digit unit
// registers; the ten characters of a run then follow in consecutive cycles
// throughput: set by the digit unit, which produces one character per cycle; a
// short command queue lets new transactions be taken while a run is still in
// progress
// each decimal digit is found by comparing the remainder against the nine
// multiples of the current power of ten and subtracting the largest fit
// reset: queue empties, no run in progress, no strobe
// the receiver cannot stall: each strobe lasts exactly one cycle
module binary_to_ascii_digits #(
  parameter int unsigned QueueDepth = b2a_pkg::QueueDepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  b2a_pkg::b2a_in_t  item_i,
  output logic              busy_o,
  output logic              result_valid_o,
  output b2a_pkg::b2a_out_t result_o
);
  import b2a_pkg::*;

  b2a_qstat_t qstat;
  b2a_cmd_t   push_cmd, head_cmd;
  logic       push, pop;

  b2a_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .item_i  (item_i),
    .busy_o  (busy_o),
    .qstat_i (qstat),
    .push_o  (push),
    .cmd_o   (push_cmd)
  );

  b2a_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .cmd_o   (head_cmd),
    .qstat_o (qstat)
  );

  b2a_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .qstat_i        (qstat),
    .cmd_i          (head_cmd),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

// ----- sv/b2a_front.sv -----
module b2a_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  b2a_pkg::b2a_in_t    item_i,
  output logic                busy_o,
  input  b2a_pkg::b2a_qstat_t qstat_i,
  output logic                push_o,
  output b2a_pkg::b2a_cmd_t   cmd_o
);
  import b2a_pkg::*;

  logic     valid_q, valid_d;
  b2a_cmd_t cmd_q;
  logic     accept;

  assign busy_o = valid_q && qstat_i.full;
  assign accept = start_i && !busy_o;
  assign push_o = valid_q && !qstat_i.full;
  assign cmd_o  = cmd_q;

  assign valid_d = accept || (valid_q && !push_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // classify radix on entry
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q.radix <= item_i.op ? RADIX_DEC : RADIX_HEX;
      cmd_q.value <= item_i.number;
    end
  end

endmodule

// ----- sv/b2a_queue.sv -----
module b2a_queue #(
  parameter int unsigned Depth = b2a_pkg::QueueDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  b2a_pkg::b2a_cmd_t   cmd_i,
  input  logic                pop_i,
  output b2a_pkg::b2a_cmd_t   cmd_o,
  output b2a_pkg::b2a_qstat_t qstat_o
);
  import b2a_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  b2a_cmd_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign qstat_o.full  = (cnt_q == CntW'(Depth));
  assign qstat_o.avail = (cnt_q != '0);
  assign do_push       = push_i && !qstat_o.full;
  assign do_pop        = pop_i && qstat_o.avail;
  assign cmd_o         = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ----- sv/b2a_back.sv -----
module b2a_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  b2a_pkg::b2a_qstat_t qstat_i,
  input  b2a_pkg::b2a_cmd_t   cmd_i,
  output logic                pop_o,
  output logic                result_valid_o,
  output b2a_pkg::b2a_out_t   result_o
);
  import b2a_pkg::*;

  logic [MultW-1:0]  mult_tab [NumDigits][DecRadix];

  logic              active_q, active_d;
  b2a_radix_e        radix_q, radix_d;
  logic [ValueW-1:0] rem_q, rem_d;
  logic [PosW-1:0]   pos_q, pos_d;

  logic              out_valid_q;
  logic [CharW-1:0]  char_q, char_d;
  logic              last_q;

  logic [PosW-1:0]   pow;
  logic [NumMult-1:0] ge;
  logic [DigitW-1:0] dec_digit, hex_digit, digit;
  logic [MultW-1:0]  sub;
  logic              at_last;

  // d * 10^p constants
  for (genvar p = 0; p < NumDigits; p++) begin : g_pow
    for (genvar d = 0; d < DecRadix; d++) begin : g_mul
      assign mult_tab[p][d] = dec_mult(p, d);
    end
  end

  assign pow     = LastPos - pos_q;
  assign at_last = (pos_q == LastPos);
  assign pop_o   = qstat_i.avail && (!active_q || at_last);

  always_comb begin
    for (int d = 1; d < DecRadix; d++) begin
      ge[d-1] = {{(MultW - ValueW){1'b0}}, rem_q} >= mult_tab[pow][d];
    end
    dec_digit = DigitW'($countones(ge));
    sub       = mult_tab[pow][dec_digit];
    hex_digit = (pow > LastHexNibble) ? '0 : rem_q[{pow[2:0], 2'b00} +: DigitW];
    digit     = (radix_q == RADIX_DEC) ? dec_digit : hex_digit;
    char_d    = (digit > MaxDecDigit) ? {4'b0, digit} + AsciiAlphaOfs
                                      : {4'b0, digit} + AsciiZero;
  end

  always_comb begin
    active_d = active_q;
    radix_d  = radix_q;
    rem_d    = rem_q;
    pos_d    = pos_q;
    if (pop_o) begin
      active_d = 1'b1;
      radix_d  = cmd_i.radix;
      rem_d    = cmd_i.value;
      pos_d    = '0;
    end else if (active_q && at_last) begin
      active_d = 1'b0;
    end else if (active_q) begin
      pos_d = pos_q + PosW'(1);
      if (radix_q == RADIX_DEC) begin
        rem_d = rem_q - sub[ValueW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      out_valid_q <= active_q;
    end
  end

  always_ff @(posedge clk_i) begin
    radix_q <= radix_d;
    rem_q   <= rem_d;
    pos_q   <= pos_d;
    char_q  <= char_d;
    last_q  <= at_last;
  end

  assign result_valid_o      = out_valid_q;
  assign result_o.digit_char = char_q;
  assign result_o.last       = last_q;

endmodule

// ----- sv/b2a_checker.sv -----
module b2a_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input b2a_pkg::b2a_in_t  item_i,
  input logic              busy_o,
  input logic              result_valid_o,
  input b2a_pkg::b2a_out_t result_o
);
  import b2a_pkg::*;

  // a run never breaks before its last character
  a_run_continuous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.last |=> result_valid_o)
    else $error("character run broke before last");

  // last closes a run of ten strobes
  a_run_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.last |->
      $past(result_valid_o, 9) && !$past(result_o.last, 1))
    else $error("run length is not ten");

  // only digit characters leave the block
  a_legal_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |->
      (result_o.digit_char >= 8'h30 && result_o.digit_char <= 8'h39) ||
      (result_o.digit_char >= 8'h41 && result_o.digit_char <= 8'h46))
    else $error("non-digit character");

  // busy only rises after a transaction request
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i))
    else $error("busy rose without start");

endmodule

bind binary_to_ascii_digits b2a_checker u_b2a_checker (.*);

// ----- bench/b2a_digit_checker.sv -----
`timescale 1ns / 100ps

module b2a_digit_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  b2a_pkg::b2a_in_t  item_i,
  input  logic              result_valid_i,
  input  b2a_pkg::b2a_out_t result_i,
  output int                fail_count_o,
  output int                pending_o,
  output int                checked_o
);
  import b2a_pkg::*;

  localparam int unsigned HexRadix = 16;

  b2a_out_t expected_chars[$];
  int       fail_count;
  int       checked;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic void push_ascii_run(input b2a_in_t item);
    logic [ValueW-1:0] rest;
    logic [ValueW-1:0] base;
    logic [DigitW-1:0] digit;
    b2a_out_t          run [NumDigits];
    rest = item.number;
    base = (b2a_radix_e'(item.op) == RADIX_DEC) ? ValueW'(DecRadix) : ValueW'(HexRadix);
    for (int pos = NumDigits - 1; pos >= 0; pos--) begin
      digit = DigitW'(rest % base);
      if (digit > MaxDecDigit) begin
        run[pos].digit_char = AsciiAlphaOfs + CharW'(digit);
      end else begin
        run[pos].digit_char = AsciiZero + CharW'(digit);
      end
      run[pos].last = (pos == NumDigits - 1);
      rest = rest / base;
    end
    for (int k = 0; k < NumDigits; k++) begin
      expected_chars.push_back(run[k]);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    b2a_out_t want;
    if (!rst_ni) begin
      expected_chars.delete();
    end else begin
      if (result_valid_i) begin
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected character 8'h%02h last=%0b",
                                    result_i.digit_char, result_i.last));
        end else begin
          want = expected_chars.pop_front();
          checked++;
          if (result_i.digit_char !== want.digit_char) begin
            report_mismatch($sformatf("digit_char got 8'h%02h want 8'h%02h",
                                      result_i.digit_char, want.digit_char));
          end
          if (result_i.last !== want.last) begin
            report_mismatch($sformatf("last got %0b want %0b", result_i.last, want.last));
          end
        end
      end
      if (start_i && !busy_i) begin
        push_ascii_run(item_i);
      end
    end
    fail_count_o <= fail_count;
    pending_o    <= expected_chars.size();
    checked_o    <= checked;
  end

endmodule

// ----- bench/tb_binary_to_ascii_digits.sv -----
`timescale 1ns / 100ps

module tb_binary_to_ascii_digits;
  import b2a_pkg::*;

  localparam int IdleLimit   = 200;
  localparam int RandomItems = 330;
  localparam int MaxGap      = 16;
  localparam int TailCycles  = 20;

  logic     clk_i   = 1'b0;
  logic     rst_ni  = 1'b0;
  logic     start_i = 1'b0;
  b2a_in_t  item_i  = '0;
  logic     busy_o;
  logic     result_valid_o;
  b2a_out_t result_o;

  int fail_count;
  int pending;
  int checked;
  int idle_cycles = 0;
  int dec_items   = 0;
  int hex_items   = 0;

  logic [ValueW-1:0] directed_values [12] = '{
    32'd0, 32'd1, 32'd9, 32'd10, 32'd15, 32'd16,
    32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98,
    32'd999_999_999, 32'd1_000_000_000, 32'hFFFF_FFFF
  };

  binary_to_ascii_digits dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .item_i         (item_i),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  b2a_digit_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_i         (busy_o),
    .item_i         (item_i),
    .result_valid_i (result_valid_o),
    .result_i       (result_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .checked_o      (checked)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || result_valid_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(input b2a_in_t item, input int gap);
    if (gap > 0) begin
      start_i <= 1'b0;
      item_i  <= {1'($urandom), ValueW'($urandom)};
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    item_i  <= item;
    if (b2a_radix_e'(item.op) == RADIX_DEC) begin
      dec_items++;
    end else begin
      hex_items++;
    end
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    start_i <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (pending != 0);
  endtask

  function automatic logic [ValueW-1:0] random_number();
    logic [ValueW-1:0] pow10;
    pow10 = ValueW'(1);
    case ($urandom_range(0, 5))
      0: return ValueW'($urandom_range(0, 255));
      1: return (ValueW'(1) << $urandom_range(0, 31)) - ValueW'($urandom_range(0, 1));
      2: return 32'hFFFF_FFFF - ValueW'($urandom_range(0, 1000));
      3: begin
        repeat ($urandom_range(1, 9)) pow10 = pow10 * ValueW'(DecRadix);
        return pow10 - ValueW'($urandom_range(0, 2)) + ValueW'($urandom_range(0, 2));
      end
      default: return ValueW'($urandom);
    endcase
  endfunction

  initial begin
    b2a_in_t item;
    int      gap;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_values[i]) begin
      for (int op = 0; op < 2; op++) begin
        item.op     = op[0];
        item.number = directed_values[i];
        send_item(item, $urandom_range(0, MaxGap));
      end
    end
    wait_drained();

    for (int i = 0; i < RandomItems; i++) begin
      // bursts with no idle time between transactions
      gap = ((i / 40) % 3 == 1) ? 0 : $urandom_range(0, MaxGap);
      item.op     = 1'($urandom_range(0, 1));
      item.number = random_number();
      send_item(item, gap);
      if (i % 97 == 50) begin
        wait_drained();
      end
    end
    wait_drained();
    repeat (TailCycles) @(posedge clk_i);

    $display("covered %0d conversions (%0d decimal, %0d hex) with random gaps and bursts",
             dec_items + hex_items, dec_items, hex_items);
    $display("compared %0d characters, %0d mismatches", checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/b2a_pkg.sv
sv/b2a_front.sv
sv/b2a_queue.sv
sv/b2a_back.sv
sv/binary_to_ascii_digits.sv
sv/b2a_checker.sv
bench/b2a_digit_checker.sv
bench/tb_binary_to_ascii_digits.sv
